FILE: rtl/abm_pkg.sv
// Shared types, codes and default parameters for the AHB burst master.
package abm_pkg;

    localparam int MAX_BEATS_DEF  = 64;
    localparam int ADDR_WIDTH_DEF = 32;

    // Command codes of an input word.
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Transfer type codes.
    localparam logic [1:0] TR_IDLE = 2'd0;
    localparam logic [1:0] TR_NSEQ = 2'd2;
    localparam logic [1:0] TR_SEQ  = 2'd3;

    // Burst codes.
    localparam logic [2:0] BU_SINGLE = 3'd0;
    localparam logic [2:0] BU_INCR   = 3'd1;
    localparam logic [2:0] BU_WRAP4  = 3'd2;
    localparam logic [2:0] BU_INCR4  = 3'd3;
    localparam logic [2:0] BU_WRAP8  = 3'd4;
    localparam logic [2:0] BU_INCR8  = 3'd5;
    localparam logic [2:0] BU_WRAP16 = 3'd6;
    localparam logic [2:0] BU_INCR16 = 3'd7;

    // Size codes.
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // Response codes.
    localparam logic [1:0] RESP_OKAY  = 2'd0;
    localparam logic [1:0] RESP_ERROR = 2'd1;
    localparam logic [1:0] RESP_RETRY = 2'd2;
    localparam logic [1:0] RESP_SPLIT = 2'd3;

    // Completion status codes.
    localparam logic [1:0] ST_OKAY  = 2'd0;
    localparam logic [1:0] ST_BURST = 2'd1;
    localparam logic [1:0] ST_ADDR  = 2'd2;
    localparam logic [1:0] ST_BUS   = 2'd3;

    // Transaction phase, one-hot.
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_BREQ = 6'b000010,
        PH_NSEQ = 6'b000100,
        PH_SEQ  = 6'b001000,
        PH_LAST = 6'b010000,
        PH_WAIT = 6'b100000
    } phase_t;

    // Decoded fields of a start word.
    typedef struct packed {
        logic       ok;
        logic [1:0] status;
        logic [2:0] code;
        logic [1:0] size;
        logic [8:0] beats;
        logic [8:0] wrap_bytes;
    } start_dec_t;

endpackage

FILE: rtl/abm_ram.sv
// Generic single-port-write RAM with a registered read port.
module abm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/abm_start_dec.sv
// Decoder that checks a start word and derives burst code and size.
module abm_start_dec #(
    parameter int MAX_BEATS  = abm_pkg::MAX_BEATS_DEF,
    parameter int ADDR_WIDTH = abm_pkg::ADDR_WIDTH_DEF
) (
    input  logic [ADDR_WIDTH-1:0] start_addr,
    input  logic [2:0]            beat_bytes,
    input  logic [8:0]            length_bytes,
    input  logic [8:0]            wrap_len,
    output abm_pkg::start_dec_t   dec
);

    logic       wrap;
    logic [1:0] sz;
    logic       sz_ok;
    logic [8:0] beats;
    logic [2:0] code;
    logic [1:0] amask;
    logic [10:0] span;

    always_comb begin
        wrap  = (wrap_len != 9'd0);
        sz_ok = 1'b1;
        case (beat_bytes)
            3'd1:    sz = abm_pkg::SZ_BYTE;
            3'd2:    sz = abm_pkg::SZ_HALF;
            3'd4:    sz = abm_pkg::SZ_WORD;
            default: begin
                sz    = abm_pkg::SZ_WORD;
                sz_ok = 1'b0;
            end
        endcase
        beats = length_bytes >> sz;
        case (beats)
            9'd1:    code = abm_pkg::BU_SINGLE;
            9'd4:    code = wrap ? abm_pkg::BU_WRAP4  : abm_pkg::BU_INCR4;
            9'd8:    code = wrap ? abm_pkg::BU_WRAP8  : abm_pkg::BU_INCR8;
            9'd16:   code = wrap ? abm_pkg::BU_WRAP16 : abm_pkg::BU_INCR16;
            default: code = abm_pkg::BU_INCR;
        endcase
        amask = (2'b01 << sz) - 2'd1;
        // Bytes of the burst: beats shifted back equal the truncated length.
        span  = {1'b0, start_addr[9:0]} + {2'b00, beats << sz};

        dec.code       = code;
        dec.size       = sz;
        dec.beats      = beats;
        dec.wrap_bytes = (code == abm_pkg::BU_WRAP4 || code == abm_pkg::BU_WRAP8 ||
                          code == abm_pkg::BU_WRAP16) ? (beats << sz) : 9'd0;
        dec.ok     = 1'b0;
        dec.status = abm_pkg::ST_BURST;
        if (!sz_ok || beats == 9'd0 || beats > 9'(MAX_BEATS)) begin
            dec.status = abm_pkg::ST_BURST;
        end else if (wrap && wrap_len != length_bytes) begin
            dec.status = abm_pkg::ST_BURST;
        end else if ((start_addr[1:0] & amask) != 2'd0) begin
            dec.status = abm_pkg::ST_ADDR;
        end else if ((code == abm_pkg::BU_INCR4 || code == abm_pkg::BU_INCR8 ||
                      code == abm_pkg::BU_INCR16) && span > 11'h400) begin
            dec.status = abm_pkg::ST_ADDR;
        end else begin
            dec.ok     = 1'b1;
            dec.status = abm_pkg::ST_OKAY;
        end
    end

endmodule

FILE: rtl/ahb_burst_master.sv
// Top level of the AHB burst master: input register, control, result register.
//
//   channel | direction | content
//   s_      | in        | push / start / bus tick word
//   m_      | out       | bus drive signals, read beat and completion status
//
// Every input word yields exactly one result word, one per cycle unless m_ stalls.
// A word is registered, then processed, and its result held in the output register;
// the write buffer is read one word ahead, so it adds no stage.
// A stall on m_ holds the pipeline; s_tready follows from the output slot.
// Reset clears all control state; the write buffer is not cleared.
module ahb_burst_master #(
    parameter int MAX_BEATS  = abm_pkg::MAX_BEATS_DEF,
    parameter int ADDR_WIDTH = abm_pkg::ADDR_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0] start_addr[33:2] beat_bytes[36:34] length_bytes[45:37]
    // wrap_len[54:46] is_write[55] write_beat[87:56] grant[88]
    // ready_req[89] response[91:90] read_word[123:92], zero to 128
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bus_trans[1:0] bus_burst[4:2] bus_addr[36:5] bus_size[38:37]
    // bus_write[39] bus_wdata[71:40] bus_request[72] read_valid[73]
    // read_data[105:74] beat_index[111:106] done_res[112] status[114:113],
    // zero to 120
    output logic [119:0] m_tdata
);

    localparam int IW = $clog2(MAX_BEATS);
    localparam int CW = $clog2(MAX_BEATS + 1);

    // Stage one: registered input word, then the buffer read settles.
    logic         s1_valid_reg;
    logic [127:0] s1_data_reg;
    logic         adv;
    logic         out_free;

    assign out_free = !m_tvalid || m_tready;
    assign adv      = out_free;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_data_reg <= s_tdata;
        end
    end

    // Field split.
    logic [1:0]            cmd;
    logic [ADDR_WIDTH-1:0] start_addr;
    logic [2:0]            beat_bytes;
    logic [8:0]            length_bytes, wrap_len;
    logic                  is_write, grant, ready_req;
    logic [31:0]           write_beat, read_word;
    logic [1:0]            response;

    assign cmd          = s1_data_reg[1:0];
    assign start_addr   = s1_data_reg[2 +: ADDR_WIDTH];
    assign beat_bytes   = s1_data_reg[36:34];
    assign length_bytes = s1_data_reg[45:37];
    assign wrap_len     = s1_data_reg[54:46];
    assign is_write     = s1_data_reg[55];
    assign write_beat   = s1_data_reg[87:56];
    assign grant        = s1_data_reg[88];
    assign ready_req    = s1_data_reg[89];
    assign response     = s1_data_reg[91:90];
    assign read_word    = s1_data_reg[123:92];

    logic go;
    assign go = s1_valid_reg && adv;

    abm_pkg::start_dec_t dec;
    abm_start_dec #(.MAX_BEATS(MAX_BEATS), .ADDR_WIDTH(ADDR_WIDTH)) u_dec (
        .start_addr, .beat_bytes, .length_bytes, .wrap_len, .dec
    );

    // State.
    abm_pkg::phase_t       phase_reg, phase_next;
    logic [ADDR_WIDTH-1:0] first_addr_reg, first_addr_next;
    logic [ADDR_WIDTH-1:0] next_addr_reg, next_addr_next;
    logic [CW-1:0]         left_reg, left_next, total_reg, total_next;
    logic [2:0]            kind_reg, kind_next, orig_reg, orig_next;
    logic [1:0]            size_reg, size_next;
    logic                  wmode_reg, wmode_next;
    logic [CW-1:0]         push_reg, push_next;
    logic [8:0]            wrapb_reg, wrapb_next;
    logic [1:0]            d_trans_reg, d_trans_next;
    logic [2:0]            d_burst_reg, d_burst_next;
    logic [ADDR_WIDTH-1:0] d_addr_reg, d_addr_next;
    logic [1:0]            d_size_reg, d_size_next;
    logic                  d_write_reg, d_write_next;
    logic [31:0]           d_wdata_reg, d_wdata_next;
    logic                  d_req_reg, d_req_next;

    // Write buffer, read ahead at the index of the beat that the next word loads.
    logic          wr_en;
    logic [31:0]   rd_data;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] idx_cur, ld_cur, ld_ahead;

    assign wr_en = go && cmd == abm_pkg::CMD_PUSH && phase_reg == abm_pkg::PH_IDLE &&
                   push_reg < CW'(MAX_BEATS);
    assign idx_cur = total_reg - left_reg;
    // In a sequential phase the beat in flight completes first, so the load
    // index is one past the current beat.
    assign ld_cur = total_reg - ((phase_reg == abm_pkg::PH_SEQ && left_reg != '0) ?
                                 left_reg - 1'b1 : left_reg);
    // Load index after the next update: the state seen now is what the next word sees.
    assign ld_ahead = total_next - ((phase_next == abm_pkg::PH_SEQ && left_next != '0) ?
                                    left_next - 1'b1 : left_next);
    assign rd_addr  = (go ? ld_ahead[IW-1:0] : ld_cur[IW-1:0]);

    abm_ram #(.WIDTH(32), .DEPTH(MAX_BEATS)) u_buf (
        .aclk, .wr_en, .wr_addr(push_reg[IW-1:0]), .wr_data(write_beat),
        .rd_addr, .rd_data
    );

    // A push to the slot being read is forwarded.
    logic        fwd_reg;
    logic [31:0] fwd_data_reg, buf_word;
    always_ff @(posedge aclk) begin
        fwd_reg      <= wr_en && push_reg[IW-1:0] == rd_addr;
        fwd_data_reg <= write_beat;
    end
    assign buf_word = fwd_reg ? fwd_data_reg : rd_data;

    // Address step: inside the wrap window when a wrap size is set, else a plain increment.
    function automatic logic [ADDR_WIDTH-1:0] step_addr(
        input logic [ADDR_WIDTH-1:0] a, input logic [1:0] sz, input logic [8:0] wb);
        logic [ADDR_WIDTH-1:0] inc, msk, sum;
        begin
            inc = ADDR_WIDTH'(3'b001 << sz);
            msk = ADDR_WIDTH'(wb) - 1'b1;
            sum = a + inc;
            step_addr = (wb != 9'd0) ? ((a & ~msk) | (sum & msk)) : sum;
        end
    endfunction

    logic           rvalid, done;
    logic [31:0]    rdata;
    logic [5:0]     rindex;
    logic [1:0]     status;
    logic [CW-1:0]  left_dec;
    logic           can_load;

    assign can_load = wmode_reg && left_reg <= total_reg && ld_cur < CW'(MAX_BEATS);

    // Transaction control for one word.
    always_comb begin
        phase_next = phase_reg; first_addr_next = first_addr_reg;
        next_addr_next = next_addr_reg; left_next = left_reg; total_next = total_reg;
        kind_next = kind_reg; orig_next = orig_reg; size_next = size_reg;
        wmode_next = wmode_reg; push_next = push_reg; wrapb_next = wrapb_reg;
        d_trans_next = d_trans_reg; d_burst_next = d_burst_reg; d_addr_next = d_addr_reg;
        d_size_next = d_size_reg; d_write_next = d_write_reg; d_wdata_next = d_wdata_reg;
        d_req_next = d_req_reg;
        rvalid = 1'b0; rdata = 32'd0; rindex = 6'd0; done = 1'b0;
        status = abm_pkg::ST_OKAY;
        left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
        if (go) begin
            case (cmd)
                abm_pkg::CMD_PUSH: begin
                    if (wr_en) push_next = push_reg + 1'b1;
                end
                abm_pkg::CMD_START: begin
                    if (phase_reg == abm_pkg::PH_IDLE) begin
                        push_next = '0;
                        if (!dec.ok) begin
                            done = 1'b1; status = dec.status;
                        end else begin
                            first_addr_next = start_addr; next_addr_next = start_addr;
                            total_next = CW'(dec.beats); left_next = CW'(dec.beats);
                            kind_next = dec.code; orig_next = dec.code;
                            size_next = dec.size; wmode_next = is_write;
                            wrapb_next = dec.wrap_bytes;
                            phase_next = abm_pkg::PH_BREQ; d_req_next = 1'b1;
                        end
                    end
                end
                abm_pkg::CMD_TICK: begin
                    case (phase_reg)
                        abm_pkg::PH_BREQ: begin
                            if (grant && ready_req) begin
                                d_write_next = wmode_reg; d_trans_next = abm_pkg::TR_NSEQ;
                                d_burst_next = kind_reg;
                                if (kind_reg != abm_pkg::BU_INCR) d_req_next = 1'b0;
                                d_addr_next = next_addr_reg;
                                next_addr_next = step_addr(next_addr_reg, size_reg, wrapb_reg);
                                d_size_next = size_reg; phase_next = abm_pkg::PH_NSEQ;
                            end
                        end
                        abm_pkg::PH_NSEQ: begin
                            if (ready_req) begin
                                if (can_load) d_wdata_next = buf_word;
                                if (!grant) begin
                                    d_trans_next = abm_pkg::TR_IDLE; d_addr_next = '0;
                                    phase_next = abm_pkg::PH_LAST;
                                end else if (kind_reg == abm_pkg::BU_SINGLE ||
                                             left_reg <= CW'(1)) begin
                                    d_trans_next = abm_pkg::TR_IDLE; d_addr_next = '0;
                                    d_req_next = 1'b0; phase_next = abm_pkg::PH_WAIT;
                                end else begin
                                    d_trans_next = abm_pkg::TR_SEQ; d_addr_next = next_addr_reg;
                                    next_addr_next = step_addr(next_addr_reg, size_reg,
                                                               wrapb_reg);
                                    phase_next = abm_pkg::PH_SEQ;
                                end
                            end
                        end
                        abm_pkg::PH_SEQ, abm_pkg::PH_LAST, abm_pkg::PH_WAIT: begin
                            if (ready_req && response == abm_pkg::RESP_OKAY) begin
                                if (!wmode_reg) begin
                                    rvalid = 1'b1; rdata = read_word; rindex = idx_cur[5:0];
                                end
                                left_next = left_dec;
                                if (phase_reg == abm_pkg::PH_SEQ) begin
                                    if (can_load) d_wdata_next = buf_word;
                                    if (!grant) begin
                                        d_trans_next = abm_pkg::TR_IDLE; d_addr_next = '0;
                                        phase_next = abm_pkg::PH_LAST;
                                    end else if (left_dec > CW'(1)) begin
                                        d_trans_next = abm_pkg::TR_SEQ;
                                        d_addr_next = next_addr_reg;
                                        next_addr_next = step_addr(next_addr_reg, size_reg,
                                                                   wrapb_reg);
                                    end else begin
                                        d_trans_next = abm_pkg::TR_IDLE; d_addr_next = '0;
                                        d_req_next = 1'b0; phase_next = abm_pkg::PH_WAIT;
                                    end
                                end else if (phase_reg == abm_pkg::PH_LAST &&
                                             left_dec != '0) begin
                                    d_req_next = 1'b1; kind_next = abm_pkg::BU_INCR;
                                    phase_next = abm_pkg::PH_BREQ;
                                end else begin
                                    phase_next = abm_pkg::PH_IDLE;
                                    d_trans_next = abm_pkg::TR_IDLE;
                                    d_addr_next = '0; d_req_next = 1'b0; done = 1'b1;
                                end
                            end else if (!ready_req && (response == abm_pkg::RESP_RETRY ||
                                                        response == abm_pkg::RESP_SPLIT)) begin
                                d_trans_next = abm_pkg::TR_IDLE; d_addr_next = '0;
                                d_req_next = 1'b1; next_addr_next = first_addr_reg;
                                left_next = total_reg; kind_next = orig_reg;
                                phase_next = abm_pkg::PH_BREQ;
                            end else if (!ready_req && response == abm_pkg::RESP_ERROR) begin
                                phase_next = abm_pkg::PH_IDLE;
                                d_trans_next = abm_pkg::TR_IDLE;
                                d_addr_next = '0; d_req_next = 1'b0;
                                done = 1'b1; status = abm_pkg::ST_BUS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= abm_pkg::PH_IDLE; first_addr_reg <= '0; next_addr_reg <= '0;
            left_reg <= '0; total_reg <= '0; kind_reg <= abm_pkg::BU_SINGLE;
            orig_reg <= abm_pkg::BU_SINGLE; size_reg <= abm_pkg::SZ_WORD;
            wmode_reg <= 1'b0; push_reg <= '0; wrapb_reg <= '0;
            d_trans_reg <= abm_pkg::TR_IDLE; d_burst_reg <= abm_pkg::BU_SINGLE;
            d_addr_reg <= '0; d_size_reg <= abm_pkg::SZ_WORD; d_write_reg <= 1'b0;
            d_wdata_reg <= '0; d_req_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; first_addr_reg <= first_addr_next;
            next_addr_reg <= next_addr_next; left_reg <= left_next;
            total_reg <= total_next; kind_reg <= kind_next; orig_reg <= orig_next;
            size_reg <= size_next; wmode_reg <= wmode_next; push_reg <= push_next;
            wrapb_reg <= wrapb_next; d_trans_reg <= d_trans_next;
            d_burst_reg <= d_burst_next; d_addr_reg <= d_addr_next;
            d_size_reg <= d_size_next; d_write_reg <= d_write_next;
            d_wdata_reg <= d_wdata_next; d_req_reg <= d_req_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_free) begin
            m_tvalid <= s1_valid_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (go) begin
            m_tdata <= {5'd0, status, done, rindex, rdata, rvalid, d_req_next,
                        d_wdata_next, d_write_next, d_size_next,
                        32'(d_addr_next), d_burst_next, d_trans_next};
        end
    end

endmodule

FILE: rtl/abm_checker.sv
// Port-level checker for the AHB burst master, bound to the top level.
module abm_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // Idle transfer drives a zero address.
    a_idle_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == abm_pkg::TR_IDLE |-> m_tdata[36:5] == 32'd0)
        else $error("address driven while idle");

    // Status is zero unless a completion is flagged.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[112] |-> m_tdata[114:113] == abm_pkg::ST_OKAY)
        else $error("status without completion");

    // Read data and index are zero without a captured beat.
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[73] |-> m_tdata[111:74] == 38'd0)
        else $error("read data without a read beat");

    // Input side is ready whenever the output slot is empty.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

endmodule

bind ahb_burst_master abm_checker u_abm_checker (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

FILE: tb/ahb_burst_master_tb.sv
// Testbench for the AHB burst master: directed and random words checked against a local model.
`timescale 1ns / 100ps

module ahb_burst_master_tb;

    localparam int NBEATS = 64;

    // Model phase codes, one-hot.
    typedef enum logic [5:0] {
        M_IDLE = 6'b000001,
        M_BREQ = 6'b000010,
        M_NSEQ = 6'b000100,
        M_SEQ  = 6'b001000,
        M_LAST = 6'b010000,
        M_WAIT = 6'b100000
    } mphase_t;

    // Result word, first member in the highest bits.
    typedef struct packed {
        logic [1:0]  status;
        logic        done;
        logic [5:0]  bidx;
        logic [31:0] rdata;
        logic        rvalid;
        logic        req;
        logic [31:0] wdata;
        logic        wr;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [2:0]  burst;
        logic [1:0]  trans;
    } bus_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;

    always #5 aclk = ~aclk;

    ahb_burst_master u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Model state.
    mphase_t     st_phase;
    logic [31:0] st_first, st_next, st_wrap;
    int unsigned st_left, st_total, st_push;
    logic [2:0]  st_burst, st_orig;
    logic [1:0]  st_size;
    logic        st_wmode;
    logic [31:0] wbuf [NBEATS];
    bus_word_t   drv;

    bus_word_t   expected_words[$];
    int          errors = 0;
    int          sent = 0;
    bit          stall_en = 1'b1;

    // Outstanding transaction tracking for stimulus.
    bit          active = 1'b0;
    bit          buf_filled = 1'b0;

    function automatic logic [31:0] next_address(logic [31:0] a);
        logic [31:0] step;
        step = 32'd1 << st_size;
        if (st_wrap != 0)
            return (a & ~(st_wrap - 1)) | ((a + step) & (st_wrap - 1));
        return a + step;
    endfunction

    function automatic void fetch_wdata();
        int unsigned idx;
        idx = st_total - st_left;
        if (st_wmode && st_left <= st_total && idx < NBEATS) drv.wdata = wbuf[idx];
    endfunction

    function automatic void model_reset();
        st_phase = M_IDLE; st_first = 0; st_next = 0; st_left = 0; st_total = 0;
        st_burst = abm_pkg::BU_SINGLE; st_orig = abm_pkg::BU_SINGLE;
        st_size = abm_pkg::SZ_WORD; st_wmode = 0;
        st_push = 0; st_wrap = 0;
        drv = '0; drv.size = abm_pkg::SZ_WORD; drv.burst = abm_pkg::BU_SINGLE;
    endfunction

    // Decodes a start word; returns the completion status.
    function automatic logic [1:0] model_start(logic [127:0] w);
        logic [31:0] a;
        logic [2:0]  bb;
        logic [8:0]  len, sw;
        logic [1:0]  sz;
        logic [2:0]  code;
        int unsigned beats, bytes;
        a = w[33:2]; bb = w[36:34]; len = w[45:37]; sw = w[54:46];
        st_push = 0;
        case (bb)
            3'd1: sz = abm_pkg::SZ_BYTE;
            3'd2: sz = abm_pkg::SZ_HALF;
            3'd4: sz = abm_pkg::SZ_WORD;
            default: return abm_pkg::ST_BURST;
        endcase
        beats = len >> sz;
        if (beats == 0 || beats > NBEATS) return abm_pkg::ST_BURST;
        if (sw != 0 && sw != len) return abm_pkg::ST_BURST;
        if (beats == 1) code = abm_pkg::BU_SINGLE;
        else if (beats == 4) code = sw != 0 ? abm_pkg::BU_WRAP4 : abm_pkg::BU_INCR4;
        else if (beats == 8) code = sw != 0 ? abm_pkg::BU_WRAP8 : abm_pkg::BU_INCR8;
        else if (beats == 16) code = sw != 0 ? abm_pkg::BU_WRAP16 : abm_pkg::BU_INCR16;
        else code = abm_pkg::BU_INCR;
        if ((a & ((32'd1 << sz) - 1)) != 0) return abm_pkg::ST_ADDR;
        bytes = beats << sz;
        if ((code == abm_pkg::BU_INCR4 || code == abm_pkg::BU_INCR8 ||
             code == abm_pkg::BU_INCR16) &&
            (a & 32'h3ff) + bytes > 32'h400) return abm_pkg::ST_ADDR;
        st_first = a; st_next = a; st_total = beats; st_left = beats;
        st_burst = code; st_orig = code; st_size = sz; st_wmode = w[55];
        st_wrap = (code == abm_pkg::BU_WRAP4 || code == abm_pkg::BU_WRAP8 ||
                   code == abm_pkg::BU_WRAP16) ? bytes : 0;
        st_phase = M_BREQ; drv.req = 1;
        return abm_pkg::ST_OKAY;
    endfunction

    // Computes the result word of one input word.
    function automatic bus_word_t model_step(logic [127:0] w);
        bus_word_t r;
        logic gnt, rdy;
        logic [1:0] resp;
        drv.rvalid = 0; drv.rdata = 0; drv.bidx = 0; drv.done = 0;
        drv.status = abm_pkg::ST_OKAY;
        gnt = w[88]; rdy = w[89]; resp = w[91:90];
        case (w[1:0])
            abm_pkg::CMD_PUSH: if (st_phase == M_IDLE && st_push < NBEATS) begin
                wbuf[st_push] = w[87:56];
                st_push++;
            end
            abm_pkg::CMD_START: if (st_phase == M_IDLE) begin
                drv.status = model_start(w);
                drv.done = drv.status != abm_pkg::ST_OKAY;
            end
            abm_pkg::CMD_TICK: begin
                if (st_phase == M_BREQ) begin
                    if (gnt && rdy) begin
                        drv.wr = st_wmode; drv.trans = abm_pkg::TR_NSEQ;
                        drv.burst = st_burst;
                        if (st_burst != abm_pkg::BU_INCR) drv.req = 0;
                        drv.addr = st_next; st_next = next_address(st_next);
                        drv.size = st_size; st_phase = M_NSEQ;
                    end
                end else if (st_phase == M_NSEQ) begin
                    if (rdy) begin
                        fetch_wdata();
                        if (!gnt) begin
                            drv.trans = abm_pkg::TR_IDLE; drv.addr = 0; st_phase = M_LAST;
                        end else if (st_burst == abm_pkg::BU_SINGLE || st_left <= 1) begin
                            drv.trans = abm_pkg::TR_IDLE; drv.addr = 0; drv.req = 0;
                            st_phase = M_WAIT;
                        end else begin
                            drv.trans = abm_pkg::TR_SEQ; drv.addr = st_next;
                            st_next = next_address(st_next); st_phase = M_SEQ;
                        end
                    end
                end else if (st_phase != M_IDLE) begin
                    if (rdy && resp == abm_pkg::RESP_OKAY) begin
                        if (!st_wmode) begin
                            drv.rvalid = 1; drv.rdata = w[123:92];
                            drv.bidx = 6'(st_total - st_left);
                        end
                        if (st_left > 0) st_left--;
                        if (st_phase == M_SEQ) begin
                            fetch_wdata();
                            if (!gnt) begin
                                drv.trans = abm_pkg::TR_IDLE; drv.addr = 0; st_phase = M_LAST;
                            end else if (st_left > 1) begin
                                drv.trans = abm_pkg::TR_SEQ; drv.addr = st_next;
                                st_next = next_address(st_next);
                            end else begin
                                drv.trans = abm_pkg::TR_IDLE; drv.addr = 0; drv.req = 0;
                                st_phase = M_WAIT;
                            end
                        end else if (st_phase == M_LAST && st_left != 0) begin
                            drv.req = 1; st_burst = abm_pkg::BU_INCR; st_phase = M_BREQ;
                        end else begin
                            st_phase = M_IDLE; drv.trans = abm_pkg::TR_IDLE; drv.addr = 0;
                            drv.req = 0; drv.done = 1; drv.status = abm_pkg::ST_OKAY;
                        end
                    end else if (!rdy && (resp == abm_pkg::RESP_RETRY ||
                                          resp == abm_pkg::RESP_SPLIT)) begin
                        drv.trans = abm_pkg::TR_IDLE; drv.addr = 0; drv.req = 1;
                        st_next = st_first; st_left = st_total; st_burst = st_orig;
                        st_phase = M_BREQ;
                    end else if (!rdy && resp == abm_pkg::RESP_ERROR) begin
                        st_phase = M_IDLE; drv.trans = abm_pkg::TR_IDLE; drv.addr = 0;
                        drv.req = 0; drv.done = 1; drv.status = abm_pkg::ST_BUS;
                    end
                end
            end
            default: ;
        endcase
        r = drv;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sends one word and queues its expected result.
    task automatic send_word(logic [127:0] w);
        int g;
        g = stall_en ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_words.push_back(model_step(w));
        sent++;
        if (expected_words[$].done) active = 0;
    endtask

    // Result checker.
    initial begin
        bus_word_t got, exp_w;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata[114:0];
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("Unexpected word %h", got);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got !== exp_w) begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected %h actual %h", exp_w, got);
                    end
                end
            end
        end
    end

    // Receiver stalls.
    always @(posedge aclk) begin
        if (!stall_en) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) < 70);
    end

    function automatic logic [127:0] push_word(logic [31:0] d);
        logic [127:0] w;
        w = '0; w[1:0] = abm_pkg::CMD_PUSH; w[87:56] = d;
        return w;
    endfunction

    function automatic logic [127:0] start_word(logic [31:0] a, logic [2:0] bb,
                                                logic [8:0] len, logic [8:0] sw, logic wr);
        logic [127:0] w;
        w = '0; w[1:0] = abm_pkg::CMD_START; w[33:2] = a; w[36:34] = bb;
        w[45:37] = len; w[54:46] = sw; w[55] = wr;
        return w;
    endfunction

    function automatic logic [127:0] tick_word(logic g, logic r, logic [1:0] resp,
                                               logic [31:0] d);
        logic [127:0] w;
        w = '0; w[1:0] = abm_pkg::CMD_TICK; w[88] = g; w[89] = r; w[91:90] = resp;
        w[123:92] = d;
        return w;
    endfunction

    // Runs one transaction: pushes beats for writes, starts, then ticks until done.
    task automatic run_txn(logic [31:0] a, logic [2:0] bb, logic [8:0] len,
                           logic [8:0] sw, logic wr, int noise);
        int n, guard;
        logic g, r;
        logic [1:0] resp;
        n = (bb == 1) ? len : (bb == 2) ? len >> 1 : len >> 2;
        // The first write fills the whole buffer so no unwritten entry is ever sent.
        if (n > NBEATS || !buf_filled) n = NBEATS;
        if (wr) begin
            for (int i = 0; i < n; i++) send_word(push_word($urandom()));
            buf_filled = 1'b1;
        end
        active = 1;
        send_word(start_word(a, bb, len, sw, wr));
        guard = 0;
        while (active && guard < 400) begin
            g = ($urandom_range(0, 99) >= noise / 2);
            r = ($urandom_range(0, 99) >= noise);
            resp = abm_pkg::RESP_OKAY;
            if ($urandom_range(0, 99) < noise / 3) resp = 2'($urandom_range(1, 3));
            if (guard > 150 && resp == abm_pkg::RESP_ERROR) resp = abm_pkg::RESP_OKAY;
            if (guard > 150) resp = r ? abm_pkg::RESP_OKAY : resp;
            send_word(tick_word(g, r, resp, $urandom()));
            guard++;
        end
        // Force an end if a long retry loop kept it going.
        while (active) begin
            if (st_phase == M_BREQ || st_phase == M_NSEQ)
                send_word(tick_word(1'b1, 1'b1, abm_pkg::RESP_OKAY, 32'd0));
            else
                send_word(tick_word(1'b1, 1'b0, abm_pkg::RESP_ERROR, 32'd0));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_directed();
        run_txn(32'h0, 3'd4, 9'd4, 9'd0, 1'b0, 0);          // single word read
        run_txn(32'h100, 3'd4, 9'd16, 9'd0, 1'b1, 0);       // incr4 write
        run_txn(32'h104, 3'd4, 9'd16, 9'd16, 1'b0, 0);      // wrap4
        run_txn(32'hFFFF_FFF8, 3'd1, 9'd8, 9'd8, 1'b0, 0);  // wrap8 bytes, top address
        run_txn(32'h2, 3'd2, 9'd32, 9'd32, 1'b1, 0);        // wrap16 halfwords
        run_txn(32'h0, 3'd4, 9'd256, 9'd0, 1'b0, 0);        // incr, 64 beats
        run_txn(32'h10, 3'd4, 9'd12, 9'd12, 1'b0, 0);       // odd wrap runs as incr
        run_txn(32'h0, 3'd3, 9'd8, 9'd0, 1'b0, 0);          // invalid size
        run_txn(32'h0, 3'd1, 9'd0, 9'd0, 1'b0, 0);          // zero beats
        run_txn(32'h0, 3'd1, 9'd256, 9'd0, 1'b0, 0);        // too many beats
        run_txn(32'h0, 3'd4, 9'd16, 9'd8, 1'b0, 0);         // wrap length mismatch
        run_txn(32'h1, 3'd4, 9'd4, 9'd0, 1'b0, 0);          // misaligned
        run_txn(32'h3F8, 3'd4, 9'd16, 9'd0, 1'b0, 0);       // 1KB crossing
        send_word(tick_word(1, 1, abm_pkg::RESP_OKAY, 32'hFFFF_FFFF)); // tick while idle
        send_word({126'd0, abm_pkg::CMD_UNUSED});            // unused command
    endtask

    task automatic test_random(int count);
        logic [2:0] bb;
        logic [8:0] len, sw;
        logic [31:0] a;
        int k;
        while (sent < count) begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                // Noise: pushes while idle and odd commands.
                send_word({$urandom(), $urandom(), $urandom(), $urandom()}
                          & {4{32'hFFFF_FFFC}} | 128'(2'($urandom_range(0, 3))));
                // A stray start that succeeded must be run out with ticks.
                if (st_phase != M_IDLE) begin
                    active = 1;
                    while (active)
                        send_word(tick_word(1, 1, abm_pkg::RESP_OKAY, $urandom()));
                end
                continue;
            end
            bb = (k < 15) ? 3'($urandom_range(0, 7)) : 3'(1 << $urandom_range(0, 2));
            case ($urandom_range(0, 4))
                0: len = 9'(bb);
                1: len = 9'(bb * (4 << $urandom_range(0, 2)));
                2: len = 9'(bb * $urandom_range(1, 20));
                3: len = 9'($urandom_range(0, 256));
                default: len = 9'(bb * (4 << $urandom_range(0, 2)));
            endcase
            sw = ($urandom_range(0, 2) == 0) ? len :
                 ($urandom_range(0, 9) == 0 ? 9'($urandom_range(0, 256)) : 9'd0);
            a = $urandom();
            if ($urandom_range(0, 3) != 0) a = a & ~32'((bb == 4) ? 3 : (bb == 2) ? 1 : 0);
            run_txn(a, bb, len, sw, $urandom_range(0, 1), $urandom_range(0, 40));
        end
    endtask

    task automatic test_pause();
        wait_drained();
        stall_en = 0;
        run_txn(32'h40, 3'd2, 9'd16, 9'd0, 1'b1, 20);
        stall_en = 1;
    endtask

    initial begin
        model_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_pause();
        test_random(450);
        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
